@@ src/cbcr_pkg.sv @@
// Shared types, widths and helpers for the circle and box collision block.
package cbcr_pkg;

  // Numerator, divisor and quotient widths of the reflection division.
  localparam int NumW = 96;
  localparam int DenW = 62;
  localparam int QW   = 33;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic        [30:0] circle_radius;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] box_left;
    logic signed [31:0] box_right;
    logic signed [31:0] box_bottom;
    logic signed [31:0] box_top;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic               degenerate_normal;
  } out_t;

  // Per-item side information that travels alongside the division.
  typedef struct packed {
    logic               hit;
    logic               deg;
    logic               neg_x;
    logic               neg_y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [NumW-1:0]  num_x;
    logic [NumW-1:0]  num_y;
    logic [DenW-1:0]  den;
  } div_in_t;

  typedef struct packed {
    side_t            side;
    logic [QW-1:0]    q_x;
    logic [QW-1:0]    q_y;
    logic [DenW-1:0]  rem_x;
    logic [DenW-1:0]  rem_y;
    logic [DenW-1:0]  den;
  } div_out_t;

  // Saturate a 36-bit signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ src/cbcr_front.sv @@
// Front pipeline: clamp, distance, hit test and reflection numerators.
module cbcr_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  cbcr_pkg::in_t     data_i,
  output logic              valid_o,
  output cbcr_pkg::div_in_t data_o
);
  import cbcr_pkg::*;

  // Squared length below which the normal counts as degenerate.
  localparam logic [62:0] Thr = 63'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);

  logic [7:0] v_q;

  // Stage 1 registers.
  logic signed [31:0] s1_cx_q, s1_cy_q, s1_clx_q, s1_cly_q, s1_vx_q, s1_vy_q;
  logic        [30:0] s1_r_q;
  // Stage 2 registers.
  logic signed [32:0] s2_dx_q, s2_dy_q;
  logic signed [31:0] s2_vx_q, s2_vy_q;
  logic        [30:0] s2_r_q;
  // Stage 3 registers.
  logic        [30:0] s3_ux_q, s3_uy_q, s3_r_q;
  logic signed [31:0] s3_dx_q, s3_dy_q, s3_vx_q, s3_vy_q;
  logic               s3_far_q;
  // Stage 4 registers.
  logic        [61:0] s4_sqx_q, s4_sqy_q, s4_rr_q;
  logic signed [63:0] s4_pvx_q, s4_pvy_q;
  logic        [30:0] s4_ux_q, s4_uy_q;
  logic               s4_far_q, s4_sdx_q, s4_sdy_q;
  logic signed [31:0] s4_vx_q, s4_vy_q;
  // Stage 5 registers.
  logic        [62:0] s5_dist2_q;
  logic signed [64:0] s5_vd_q;
  logic        [61:0] s5_rr_q;
  logic        [30:0] s5_ux_q, s5_uy_q;
  logic               s5_far_q, s5_sdx_q, s5_sdy_q;
  logic signed [31:0] s5_vx_q, s5_vy_q;
  // Stage 6 registers.
  side_t              s6_side_q;
  logic        [62:0] s6_mvd_q;
  logic        [31:0] s6_mdx_q, s6_mdy_q;
  logic        [61:0] s6_den_q;
  // Stage 7 registers.
  side_t              s7_side_q;
  logic        [63:0] s7_plx_q, s7_ply_q;
  logic        [62:0] s7_phx_q, s7_phy_q;
  logic        [61:0] s7_den_q;
  // Stage 8 register.
  div_in_t            s8_q;

  logic signed [31:0] minx, miny, clx_d, cly_d;
  logic signed [32:0] magx, magy;
  logic signed [64:0] vd_abs;
  logic               hit_d;

  // Clamp the centre onto the box: max(low, min(centre, high)).
  always_comb begin
    minx  = (data_i.center_x < data_i.box_right) ? data_i.center_x : data_i.box_right;
    clx_d = (data_i.box_left > minx) ? data_i.box_left : minx;
    miny  = (data_i.center_y < data_i.box_top) ? data_i.center_y : data_i.box_top;
    cly_d = (data_i.box_bottom > miny) ? data_i.box_bottom : miny;
  end

  // Magnitudes of the offsets and of the velocity dot product, and the hit test.
  always_comb begin
    magx   = s2_dx_q[32] ? -s2_dx_q : s2_dx_q;
    magy   = s2_dy_q[32] ? -s2_dy_q : s2_dy_q;
    vd_abs = s5_vd_q[64] ? -s5_vd_q : s5_vd_q;
    hit_d  = !s5_far_q && (s5_dist2_q <= {1'b0, s5_rr_q});
  end

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cx_q  <= data_i.center_x;
      s1_cy_q  <= data_i.center_y;
      s1_clx_q <= clx_d;
      s1_cly_q <= cly_d;
      s1_vx_q  <= data_i.vel_x;
      s1_vy_q  <= data_i.vel_y;
      s1_r_q   <= data_i.circle_radius;

      s2_dx_q <= {s1_cx_q[31], s1_cx_q} - {s1_clx_q[31], s1_clx_q};
      s2_dy_q <= {s1_cy_q[31], s1_cy_q} - {s1_cly_q[31], s1_cly_q};
      s2_vx_q <= s1_vx_q;
      s2_vy_q <= s1_vy_q;
      s2_r_q  <= s1_r_q;

      s3_ux_q  <= magx[30:0];
      s3_uy_q  <= magy[30:0];
      s3_far_q <= magx[32] | magx[31] | magy[32] | magy[31];
      s3_dx_q  <= s2_dx_q[31:0];
      s3_dy_q  <= s2_dy_q[31:0];
      s3_r_q   <= s2_r_q;
      s3_vx_q  <= s2_vx_q;
      s3_vy_q  <= s2_vy_q;

      s4_sqx_q <= s3_ux_q * s3_ux_q;
      s4_sqy_q <= s3_uy_q * s3_uy_q;
      s4_rr_q  <= s3_r_q * s3_r_q;
      s4_pvx_q <= s3_vx_q * s3_dx_q;
      s4_pvy_q <= s3_vy_q * s3_dy_q;
      s4_ux_q  <= s3_ux_q;
      s4_uy_q  <= s3_uy_q;
      s4_far_q <= s3_far_q;
      s4_sdx_q <= s3_dx_q[31];
      s4_sdy_q <= s3_dy_q[31];
      s4_vx_q  <= s3_vx_q;
      s4_vy_q  <= s3_vy_q;

      s5_dist2_q <= {1'b0, s4_sqx_q} + {1'b0, s4_sqy_q};
      s5_vd_q    <= {s4_pvx_q[63], s4_pvx_q} + {s4_pvy_q[63], s4_pvy_q};
      s5_rr_q    <= s4_rr_q;
      s5_ux_q    <= s4_ux_q;
      s5_uy_q    <= s4_uy_q;
      s5_far_q   <= s4_far_q;
      s5_sdx_q   <= s4_sdx_q;
      s5_sdy_q   <= s4_sdy_q;
      s5_vx_q    <= s4_vx_q;
      s5_vy_q    <= s4_vy_q;

      s6_side_q.hit   <= hit_d;
      s6_side_q.deg   <= hit_d && (s5_dist2_q <= Thr);
      s6_side_q.neg_x <= s5_vd_q[64] ^ s5_sdx_q;
      s6_side_q.neg_y <= s5_vd_q[64] ^ s5_sdy_q;
      s6_side_q.vx    <= s5_vx_q;
      s6_side_q.vy    <= s5_vy_q;
      s6_mvd_q        <= vd_abs[62:0];
      s6_mdx_q        <= {s5_ux_q, 1'b0};
      s6_mdy_q        <= {s5_uy_q, 1'b0};
      s6_den_q        <= s5_dist2_q[61:0];

      // The 63 by 32 bit product is split into two partial products.
      s7_side_q <= s6_side_q;
      s7_plx_q  <= s6_mvd_q[31:0] * s6_mdx_q;
      s7_phx_q  <= s6_mvd_q[62:32] * s6_mdx_q;
      s7_ply_q  <= s6_mvd_q[31:0] * s6_mdy_q;
      s7_phy_q  <= s6_mvd_q[62:32] * s6_mdy_q;
      s7_den_q  <= s6_den_q;

      s8_q.side  <= s7_side_q;
      s8_q.num_x <= {1'b0, s7_phx_q, 32'd0} + {32'd0, s7_plx_q};
      s8_q.num_y <= {1'b0, s7_phy_q, 32'd0} + {32'd0, s7_ply_q};
      s8_q.den   <= s7_den_q;
    end
  end

  assign valid_o = v_q[7];
  assign data_o  = s8_q;

endmodule

@@ src/cbcr_div.sv @@
// Pipelined restoring divider, one quotient bit per step stage, for both axes.
module cbcr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cbcr_pkg::div_in_t  data_i,
  output logic               valid_o,
  output cbcr_pkg::div_out_t data_o
);
  import cbcr_pkg::*;

  typedef struct packed {
    side_t           side;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
    logic [QW-1:0]   low_x;
    logic [QW-1:0]   low_y;
    logic [DenW-1:0] rem_x;
    logic [DenW-1:0] rem_y;
    logic [DenW-1:0] den;
  } st_t;

  // One restoring step on a partial remainder.
  function automatic void div_step(input logic [DenW-1:0] r, input logic b,
                                   input logic [DenW-1:0] d,
                                   output logic [DenW-1:0] r_n, output logic q);
    logic [DenW:0] t, diff;
    t    = {r, b};
    diff = t - {1'b0, d};
    q    = (t >= {1'b0, d});
    r_n  = q ? diff[DenW-1:0] : t[DenW-1:0];
  endfunction

  st_t        st_q [QW+1];
  logic [QW:0] v_q;

  // Load: the quotient fits in QW bits, so the upper numerator bits are below den.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].side  <= data_i.side;
      st_q[0].q_x   <= '0;
      st_q[0].q_y   <= '0;
      st_q[0].low_x <= data_i.num_x[QW-1:0];
      st_q[0].low_y <= data_i.num_y[QW-1:0];
      st_q[0].rem_x <= data_i.num_x[QW+DenW-1:QW];
      st_q[0].rem_y <= data_i.num_y[QW+DenW-1:QW];
      st_q[0].den   <= data_i.den;
    end
  end

  // Step stages bring down one numerator bit each.
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DenW-1:0] rx_n, ry_n;
    logic            qx_b, qy_b;

    always_comb begin
      div_step(st_q[i].rem_x, st_q[i].low_x[QW-1], st_q[i].den, rx_n, qx_b);
      div_step(st_q[i].rem_y, st_q[i].low_y[QW-1], st_q[i].den, ry_n, qy_b);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1].side  <= st_q[i].side;
        st_q[i+1].q_x   <= {st_q[i].q_x[QW-2:0], qx_b};
        st_q[i+1].q_y   <= {st_q[i].q_y[QW-2:0], qy_b};
        st_q[i+1].low_x <= {st_q[i].low_x[QW-2:0], 1'b0};
        st_q[i+1].low_y <= {st_q[i].low_y[QW-2:0], 1'b0};
        st_q[i+1].rem_x <= rx_n;
        st_q[i+1].rem_y <= ry_n;
        st_q[i+1].den   <= st_q[i].den;
      end
    end
  end

  // Valid bits follow the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-1:0], valid_i};
    end
  end

  assign valid_o      = v_q[QW];
  assign data_o.side  = st_q[QW].side;
  assign data_o.q_x   = st_q[QW].q_x;
  assign data_o.q_y   = st_q[QW].q_y;
  assign data_o.rem_x = st_q[QW].rem_x;
  assign data_o.rem_y = st_q[QW].rem_y;
  assign data_o.den   = st_q[QW].den;

endmodule

@@ src/cbcr_back.sv @@
// Back pipeline: rounding, reflection subtract and saturation.
module cbcr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cbcr_pkg::div_out_t data_i,
  output logic               valid_o,
  output cbcr_pkg::out_t     data_o
);
  import cbcr_pkg::*;

  logic [1:0]    v_q;
  side_t         b1_side_q;
  logic [QW:0]   b1_qx_q, b1_qy_q;
  out_t          b2_q;

  logic               rnd_x, rnd_y;
  logic signed [35:0] term_x, term_y, refl_x, refl_y, vx_w, vy_w;
  logic signed [31:0] ox_d, oy_d;

  // Round to nearest, ties away from zero, on the magnitude.
  always_comb begin
    rnd_x = {data_i.rem_x, 1'b0} >= {1'b0, data_i.den};
    rnd_y = {data_i.rem_y, 1'b0} >= {1'b0, data_i.den};
  end

  // Apply the signed term, or negate, or pass the velocity through.
  always_comb begin
    vx_w   = {{4{b1_side_q.vx[31]}}, b1_side_q.vx};
    vy_w   = {{4{b1_side_q.vy[31]}}, b1_side_q.vy};
    term_x = b1_side_q.neg_x ? -$signed({2'b0, b1_qx_q}) : $signed({2'b0, b1_qx_q});
    term_y = b1_side_q.neg_y ? -$signed({2'b0, b1_qy_q}) : $signed({2'b0, b1_qy_q});
    refl_x = vx_w - term_x;
    refl_y = vy_w - term_y;
    if (!b1_side_q.hit) begin
      ox_d = b1_side_q.vx;
      oy_d = b1_side_q.vy;
    end else if (b1_side_q.deg) begin
      ox_d = sat32(-vx_w);
      oy_d = sat32(-vy_w);
    end else begin
      ox_d = sat32(refl_x);
      oy_d = sat32(refl_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_side_q <= data_i.side;
      b1_qx_q   <= {1'b0, data_i.q_x} + {{QW{1'b0}}, rnd_x};
      b1_qy_q   <= {1'b0, data_i.q_y} + {{QW{1'b0}}, rnd_y};

      b2_q.hit               <= b1_side_q.hit;
      b2_q.degenerate_normal <= b1_side_q.deg;
      b2_q.out_vel_x         <= ox_d;
      b2_q.out_vel_y         <= oy_d;
    end
  end

  assign valid_o = v_q[1];
  assign data_o  = b2_q;

endmodule

@@ src/circle_box_collide_reflect.sv @@
// Top level of the circle against axis-aligned box collision and reflection block.
// Takes one circle, velocity and box per cycle and returns one result per item:
// the hit flag, the reflected (or negated, or unchanged) velocity saturated to
// 32 bits, and a flag for a near-zero normal. There are eight front stages
// for clamp, squares and products, 34 divider stages (load, then steps that
// produce one quotient bit each for the exact reflection term), and two back
// stages for rounding and saturation. A new item is taken every cycle; when
// the output is not taken the whole pipeline holds, and in_ready_o drops too.
module circle_box_collide_reflect #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cbcr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cbcr_pkg::out_t out_data_o
);
  import cbcr_pkg::*;

  logic     en;
  logic     f_valid, d_valid;
  div_in_t  f_data;
  div_out_t d_data;

  // The pipeline advances unless a finished result is waiting.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  cbcr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (f_valid),
    .data_o  (f_data)
  );

  cbcr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .data_i  (f_data),
    .valid_o (d_valid),
    .data_o  (d_data)
  );

  cbcr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .data_i  (d_data),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
